FILE: rtl/pnc_pkg.sv
`default_nettype none

package pnc_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 10;
    localparam int FUNC_W    = 2;
    localparam int POWER_W   = 31;
    localparam int POWER_LSB = 19;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 32;
    localparam logic [CFG_W-1:0] SEQ_LEN_RESET = 10'd512;

    // Item kinds carried on s_tuser. Code 3 is not used and is ignored.
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PN     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_LOAD = 3'b010,
        MODE_CORR = 3'b100
    } mode_t;

    // Strobes broadcast to every correlator cell.
    typedef struct packed {
        logic clear;   // drop all loaded chips (start of loading)
        logic shift;   // shift a new chip into the tap chain
        logic sample;  // update partial sums with the new sample
    } pnc_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pnc_cell.sv
`default_nettype none

// One tap of a transposed-form correlator. It holds its chip and an active
// flag, and a running partial sum that it hands down to the next lower tap.
module pnc_cell #(
    parameter int ACC_W = 26
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire pnc_pkg::pnc_ctrl_t             ctrl,
    input  wire logic                           chip_in,
    input  wire logic                           act_in,
    output logic                                chip_out,
    output logic                                act_out,
    input  wire logic signed [pnc_pkg::SAMPLE_W-1:0] sample_i,
    input  wire logic signed [pnc_pkg::SAMPLE_W-1:0] sample_q,
    input  wire logic signed [ACC_W-1:0]        psum_i_in,
    input  wire logic signed [ACC_W-1:0]        psum_q_in,
    output logic signed [ACC_W-1:0]             psum_i_out,
    output logic signed [ACC_W-1:0]             psum_q_out
);
    import pnc_pkg::*;

    logic                    chip_reg;
    logic                    act_reg;
    logic signed [ACC_W-1:0] psum_i_reg;
    logic signed [ACC_W-1:0] psum_q_reg;
    logic signed [ACC_W-1:0] ext_i;
    logic signed [ACC_W-1:0] ext_q;
    logic signed [ACC_W-1:0] term_i;
    logic signed [ACC_W-1:0] term_q;

    // Extend before negating so that the most negative sample stays exact.
    assign ext_i = ACC_W'(sample_i);
    assign ext_q = ACC_W'(sample_q);

    // The Q contribution is negated for the conjugate.
    always_comb begin
        if (!act_reg) begin
            term_i = '0;
            term_q = '0;
        end else if (chip_reg) begin
            term_i = ext_i;
            term_q = -ext_q;
        end else begin
            term_i = -ext_i;
            term_q = ext_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg    <= 1'b0;
            psum_i_reg <= '0;
            psum_q_reg <= '0;
        end else begin
            if (ctrl.clear) begin
                act_reg <= 1'b0;
            end else if (ctrl.shift) begin
                act_reg <= act_in;
            end
            if (ctrl.sample) begin
                psum_i_reg <= psum_i_in + term_i;
                psum_q_reg <= psum_q_in + term_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            chip_reg <= chip_in;
        end
    end

    assign chip_out   = chip_reg;
    assign act_out    = act_reg;
    assign psum_i_out = psum_i_reg;
    assign psum_q_out = psum_q_reg;

endmodule

`default_nettype wire

FILE: rtl/pnc_power.sv
`default_nettype none

// Squares the two correlation sums, adds them and holds bits 49..19 of the sum
// in the output register. Each stage moves whenever the stage after it has room.
module pnc_power #(
    parameter int ACC_W = 26
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [ACC_W-1:0] sum_i,
    input  wire logic signed [ACC_W-1:0] sum_q,
    input  wire logic                    in_last,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [pnc_pkg::POWER_W-1:0]  m_power,
    output logic                         m_tlast
);
    import pnc_pkg::*;

    localparam int SQ_W = 2 * ACC_W;

    logic                    sq_valid_reg;
    logic [SQ_W-1:0]         sq_i_reg;
    logic [SQ_W-1:0]         sq_q_reg;
    logic                    sq_last_reg;
    logic                    out_valid_reg;
    logic [POWER_W-1:0]      power_reg;
    logic                    last_reg;
    logic                    out_en;
    logic                    sq_en;
    logic signed [SQ_W-1:0]  prod_i;
    logic signed [SQ_W-1:0]  prod_q;
    logic [SQ_W-1:0]         pw;
    logic [63:0]             pw_ext;

    assign out_en   = !out_valid_reg || m_tready;
    assign sq_en    = !sq_valid_reg || out_en;
    assign in_ready = sq_en;

    assign prod_i = SQ_W'(sum_i) * SQ_W'(sum_i);
    assign prod_q = SQ_W'(sum_q) * SQ_W'(sum_q);
    assign pw     = sq_i_reg + sq_q_reg;
    assign pw_ext = 64'(pw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sq_en) begin
                sq_valid_reg <= in_valid;
            end
            if (out_en) begin
                out_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_en && in_valid) begin
            sq_i_reg    <= prod_i;
            sq_q_reg    <= prod_q;
            sq_last_reg <= in_last;
        end
        if (out_en && sq_valid_reg) begin
            power_reg <= pw_ext[POWER_LSB +: POWER_W];
            last_reg  <= sq_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_power  = power_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: rtl/pn_sequence_correlator_power.sv
// PN sequence correlator with power output.
// Input stream: s_tuser gives the transaction kind (start, PN chip, sample).
// A start transaction, acted on only while idle, latches cfg_wr_data's length
// (0 read as 1, values above TAPS read as TAPS). The next length PN-chip
// transactions load the taps; the block then stays in correlation mode.
// Every sample transaction in correlation mode gives one output transaction:
// bits 49..19 of |sum I|^2 + |sum Q|^2, where the sums run over the loaded
// chips against the conjugated samples. m_tlast marks every length-th output.
// Transactions that do not fit the current mode are taken and dropped.
// Throughput is one transaction per clock while s_tready is high. A sample
// passes through the tap chain, whose cells update their partial sums in
// parallel, then the squaring stage and then the output register.
// When m_tready is low the stages fill up, and s_tready falls only once the
// output register, the squaring stage and the chain output are all occupied.
// Reset (aresetn low, synchronous) zeroes the sample history, returns to idle
// and sets the length register to 512; chips must be reloaded after reset.
`default_nettype none

module pn_sequence_correlator_power #(
    parameter int TAPS = 512
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pnc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] pn_bit, [16:1] sample_i, [32:17] sample_q, [39:33] zero
    input  wire logic [pnc_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] func
    input  wire logic [pnc_pkg::FUNC_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [30:0] power, [31] zero
    output logic [pnc_pkg::M_DATA_W-1:0]          m_tdata,
    output logic                                  m_tlast
);
    import pnc_pkg::*;

    localparam int LEN_W = $clog2(TAPS + 1);
    localparam int ACC_W = SAMPLE_W + 1 + $clog2(TAPS);

    logic [CFG_W-1:0]        cfg_seq_len_reg;
    mode_t                   mode_reg, mode_next;
    logic [LEN_W-1:0]        active_len_reg, active_len_next;
    logic [LEN_W-1:0]        load_cnt_reg, load_cnt_next;
    logic [LEN_W-1:0]        out_count_reg, out_count_next;
    logic                    corr_valid_reg;
    logic                    corr_last_reg;
    logic                    accept;
    logic                    start_ok;
    logic                    pn_ok;
    logic                    sample_ok;
    logic                    pw_ready;
    logic                    hit_last;
    logic [31:0]             req_len;
    logic [LEN_W-1:0]        clamped_len;
    pnc_ctrl_t               ctrl;
    logic [POWER_W-1:0]      power;

    logic                    chip_chain [TAPS+1];
    logic                    act_chain  [TAPS+1];
    logic signed [ACC_W-1:0] psum_i [TAPS+1];
    logic signed [ACC_W-1:0] psum_q [TAPS+1];

    assign s_tready  = !corr_valid_reg || pw_ready;
    assign accept    = s_tvalid && s_tready;
    assign start_ok  = accept && (s_tuser == FUNC_START) && (mode_reg == MODE_IDLE);
    assign pn_ok     = accept && (s_tuser == FUNC_PN) && (mode_reg == MODE_LOAD);
    assign sample_ok = accept && (s_tuser == FUNC_SAMPLE) && (mode_reg == MODE_CORR);

    assign ctrl.clear  = start_ok;
    assign ctrl.shift  = pn_ok;
    assign ctrl.sample = sample_ok;

    always_comb begin
        req_len = 32'(cfg_seq_len_reg);
        if (req_len == 32'd0) begin
            clamped_len = LEN_W'(1);
        end else if (req_len > 32'(TAPS)) begin
            clamped_len = LEN_W'(TAPS);
        end else begin
            clamped_len = LEN_W'(req_len);
        end
    end

    assign hit_last = out_count_reg >= (active_len_reg - LEN_W'(1));

    always_comb begin
        mode_next       = mode_reg;
        active_len_next = active_len_reg;
        load_cnt_next   = load_cnt_reg;
        out_count_next  = out_count_reg;
        if (start_ok) begin
            active_len_next = clamped_len;
            load_cnt_next   = clamped_len - LEN_W'(1);
            mode_next       = MODE_LOAD;
        end
        if (pn_ok) begin
            if (load_cnt_reg == '0) begin
                mode_next = MODE_CORR;
            end else begin
                load_cnt_next = load_cnt_reg - LEN_W'(1);
            end
        end
        if (sample_ok) begin
            out_count_next = hit_last ? '0 : out_count_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_seq_len_reg <= SEQ_LEN_RESET;
            mode_reg        <= MODE_IDLE;
            active_len_reg  <= LEN_W'(TAPS);
            load_cnt_reg    <= '0;
            out_count_reg   <= '0;
            corr_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_seq_len_reg <= cfg_wr_data;
            end
            mode_reg       <= mode_next;
            active_len_reg <= active_len_next;
            load_cnt_reg   <= load_cnt_next;
            out_count_reg  <= out_count_next;
            if (s_tready) begin
                corr_valid_reg <= sample_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_ok) begin
            corr_last_reg <= hit_last;
        end
    end

    // Chips enter at tap 0 and move up, so the first chip loaded ends up at
    // the highest active tap. Partial sums flow from the top tap down to 0.
    assign chip_chain[0] = s_tdata[0];
    assign act_chain[0]  = 1'b1;
    assign psum_i[TAPS]  = '0;
    assign psum_q[TAPS]  = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        pnc_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .chip_in    (chip_chain[k]),
            .act_in     (act_chain[k]),
            .chip_out   (chip_chain[k+1]),
            .act_out    (act_chain[k+1]),
            .sample_i   (s_tdata[16:1]),
            .sample_q   (s_tdata[32:17]),
            .psum_i_in  (psum_i[k+1]),
            .psum_q_in  (psum_q[k+1]),
            .psum_i_out (psum_i[k]),
            .psum_q_out (psum_q[k])
        );
    end

    pnc_power #(
        .ACC_W (ACC_W)
    ) u_power (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (corr_valid_reg),
        .in_ready (pw_ready),
        .sum_i    (psum_i[0]),
        .sum_q    (psum_q[0]),
        .in_last  (corr_last_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_power  (power),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = M_DATA_W'(power);

    // The chain output only holds a result once correlation has begun.
    a_corr_mode : assert property (@(posedge aclk) disable iff (!aresetn)
        corr_valid_reg |-> (mode_reg == MODE_CORR))
        else $error("correlation result outside correlation mode");

    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        out_count_reg < active_len_reg)
        else $error("output counter beyond sequence length");

    a_load_done : assert property (@(posedge aclk) disable iff (!aresetn)
        (pn_ok && (load_cnt_reg == '0)) |=> (mode_reg == MODE_CORR))
        else $error("last chip did not start correlation");

    a_active_len : assert property (@(posedge aclk) disable iff (!aresetn)
        (active_len_reg != '0) && (active_len_reg <= LEN_W'(TAPS)))
        else $error("latched length out of range");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
    import pnc_pkg::*;

    localparam int TAPS        = 512;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 120;
    localparam int ITEM_BUDGET = 1300;

    // The fourth kind code has no meaning and must be dropped by the block.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RX_OPEN    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_PATTERN = 2;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHIPS, ROW_CFG, ROW_CFG_LEN} row_kind_t;
    typedef enum logic [1:0] {RES_NONE, RES_PRED, RES_POWER} res_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [FUNC_W-1:0]  func;
        logic               pn;
        logic [15:0]        si;
        logic [15:0]        sq;
        res_kind_t          res;
        logic [POWER_W-1:0] power;
        logic [CFG_W-1:0]   cfg;
    } row_t;

    typedef struct {
        logic [POWER_W-1:0] power;
        logic               last;
    } power_due_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata     = '0;
    logic [FUNC_W-1:0]    s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;

    pn_sequence_correlator_power #(.TAPS(TAPS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Predictor state.
    logic signed [15:0] hist_i [TAPS];
    logic signed [15:0] hist_q [TAPS];
    bit                 chips  [TAPS];
    mode_t              corr_mode;
    int unsigned        load_pos;
    int unsigned        out_cnt;
    int unsigned        cfg_len;
    int unsigned        taps_len;

    power_due_t power_due [$];

    // What the current transaction on the input is expected to give.
    res_kind_t          pend_res   = RES_PRED;
    logic [POWER_W-1:0] pend_power = '0;

    int  errors      = 0;
    int  n_in        = 0;
    int  n_out       = 0;
    int  n_cfg       = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    bit  hold_go     = 1'b0;
    bit  hold_done   = 1'b0;
    row_t script [20];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic correlate_item(input logic [FUNC_W-1:0] func, input bit chip,
                                  input logic signed [15:0] smp_i,
                                  input logic signed [15:0] smp_q,
                                  output bit made, output logic [POWER_W-1:0] pw,
                                  output bit lst);
        longint      sum_i;
        longint      sum_q;
        longint      mag_i;
        longint      mag_q;
        logic [63:0] energy;
        int          k;
        made  = 1'b0;
        pw    = '0;
        lst   = 1'b0;
        sum_i = 0;
        sum_q = 0;
        if (func == FUNC_START) begin
            if (corr_mode == MODE_IDLE) begin
                taps_len  = (cfg_len == 0) ? 1 : ((cfg_len > TAPS) ? TAPS : cfg_len);
                load_pos  = taps_len - 1;
                corr_mode = MODE_LOAD;
            end
        end else if (func == FUNC_PN) begin
            if (corr_mode == MODE_LOAD) begin
                chips[load_pos] = chip;
                if (load_pos == 0)
                    corr_mode = MODE_CORR;
                else
                    load_pos--;
            end
        end else if (func == FUNC_SAMPLE && corr_mode == MODE_CORR) begin
            for (k = TAPS - 1; k > 0; k--) begin
                hist_i[k] = hist_i[k-1];
                hist_q[k] = hist_q[k-1];
            end
            hist_i[0] = smp_i;
            hist_q[0] = smp_q;
            // The Q sum is taken against the conjugate, hence the flipped sign.
            for (k = 0; k < int'(taps_len); k++) begin
                if (chips[k]) begin
                    sum_i += hist_i[k];
                    sum_q -= hist_q[k];
                end else begin
                    sum_i -= hist_i[k];
                    sum_q += hist_q[k];
                end
            end
            mag_i  = (sum_i < 0) ? -sum_i : sum_i;
            mag_q  = (sum_q < 0) ? -sum_q : sum_q;
            energy = mag_i * mag_i + mag_q * mag_q;
            pw     = energy[POWER_LSB +: POWER_W];
            if (out_cnt >= taps_len - 1) begin
                lst     = 1'b1;
                out_cnt = 0;
            end else begin
                out_cnt++;
            end
            made = 1'b1;
        end
    endtask

    // Prediction and checking share one block so that their order within an edge is fixed.
    always @(posedge aclk) begin : monitor
        bit                 made;
        bit                 lst;
        logic [POWER_W-1:0] pw;
        power_due_t         due;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                n_in++;
                correlate_item(s_tuser, s_tdata[0], s_tdata[16:1], s_tdata[32:17],
                               made, pw, lst);
                if (made && pend_res != RES_NONE) begin
                    due.power = (pend_res == RES_POWER) ? pend_power : pw;
                    due.last  = lst;
                    power_due.push_back(due);
                end
            end
            if (m_tvalid && m_tready) begin
                n_out++;
                if (power_due.size() == 0) begin
                    $error("unexpected result transaction: power %0d last %0d",
                           m_tdata[POWER_W-1:0], m_tlast);
                    errors++;
                end else begin
                    due = power_due.pop_front();
                    if (m_tdata[POWER_W-1:0] !== due.power) begin
                        $error("power: expected %0d, actual %0d",
                               due.power, m_tdata[POWER_W-1:0]);
                        errors++;
                    end
                    if (m_tlast !== due.last) begin
                        $error("last: expected %0d, actual %0d", due.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d cycles without a transaction", idle_cycles);
            $display("pn_sequence_correlator_power regression: fail");
            $finish;
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off to back up the pipeline.
    initial begin : receiver
        int         rx_style;
        int         rx_left;
        logic [7:0] rx_pat;
        rx_style = RX_OPEN;
        rx_left  = 0;
        rx_pat   = 8'b1011_0110;
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (rx_left == 0) begin
                rx_style = $urandom_range(RX_OPEN, RX_PATTERN);
                rx_left  = $urandom_range(20, 150);
            end
            rx_left--;
            case (rx_style)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    m_tready <= rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[7:1]};
                end
            endcase
        end
    end

    // Offers one transaction, starting and ending at a falling edge.
    task automatic offer(input logic [FUNC_W-1:0] func, input bit pn,
                         input logic [15:0] si, input logic [15:0] sq,
                         input res_kind_t res, input logic [POWER_W-1:0] power);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        pend_res   = res;
        pend_power = power;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, sq, si, pn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Brings the block to rest so the length register may be written.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (power_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic write_len(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_len = value;
        n_cfg++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] any_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [CFG_W-1:0] len_pick;
        int               rand_samples;
        int               phase;
        int               sent;
        int               n;
        logic [FUNC_W-1:0] noise_func;

        foreach (hist_i[k]) begin
            hist_i[k] = '0;
            hist_q[k] = '0;
            chips[k]  = 1'b0;
        end
        corr_mode = MODE_IDLE;
        load_pos  = 0;
        out_cnt   = 0;
        cfg_len   = SEQ_LEN_RESET;
        taps_len  = TAPS;

        // Only the first start latches a length, so each seed exercises one of them.
        case ($urandom_range(0, 7))
            0:       len_pick = 10'd0;
            1:       len_pick = 10'd1;
            2:       len_pick = 10'd2;
            3:       len_pick = 10'd512;
            4:       len_pick = 10'd1023;
            5:       len_pick = 10'($urandom_range(3, 16));
            6:       len_pick = 10'($urandom_range(17, 100));
            default: len_pick = 10'($urandom_range(101, 511));
        endcase

        script = '{
            '{ROW_CFG,     FUNC_START,  1'b0, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b0, 16'h8000, 16'h8000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_PN,     1'b1, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_UNUSED, 1'b1, 16'hffff, 16'hffff, RES_NONE,  31'd0,    10'd0},
            '{ROW_CFG,     FUNC_START,  1'b0, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd1023},
            '{ROW_CFG_LEN, FUNC_START,  1'b0, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_START,  1'b0, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_START,  1'b1, 16'h1234, 16'h4321, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b0, 16'h7fff, 16'h7fff, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_UNUSED, 1'b0, 16'h8000, 16'h7fff, RES_NONE,  31'd0,    10'd0},
            '{ROW_CHIPS,   FUNC_PN,     1'b0, 16'h0000, 16'h0000, RES_PRED,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_PN,     1'b0, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_START,  1'b0, 16'h0000, 16'h0000, RES_NONE,  31'd0,    10'd0},
            // With an empty history the first power is just (i*i + q*q) >> 19.
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b0, 16'h8000, 16'h8000, RES_POWER, 31'd4096, 10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b1, 16'h7fff, 16'h7fff, RES_PRED,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b0, 16'h8000, 16'h7fff, RES_PRED,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b1, 16'h0000, 16'h0000, RES_PRED,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_UNUSED, 1'b1, 16'h7fff, 16'h8000, RES_NONE,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b0, 16'h7fff, 16'h8000, RES_PRED,  31'd0,    10'd0},
            '{ROW_ITEM,    FUNC_SAMPLE, 1'b1, 16'hffff, 16'h0001, RES_PRED,  31'd0,    10'd0}
        };

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[r]) begin
            case (script[r].kind)
                ROW_ITEM: begin
                    offer(script[r].func, script[r].pn, script[r].si, script[r].sq,
                          script[r].res, script[r].power);
                end
                ROW_CHIPS: begin
                    for (n = 0; n < int'(taps_len); n++)
                        offer(FUNC_PN, 1'($urandom), 16'($urandom), 16'($urandom),
                              RES_PRED, '0);
                end
                ROW_CFG: begin
                    drain();
                    write_len(script[r].cfg);
                end
                default: begin
                    drain();
                    write_len(len_pick);
                end
            endcase
        end

        // Samples dominate; starts, chips and unused codes arrive as noise the
        // block must drop. A write between phases comes too late to matter.
        rand_samples = ITEM_BUDGET - 20 - int'(taps_len);
        hold_go = 1'b1;
        for (phase = 0; phase < 4; phase++) begin
            sent = 0;
            while (sent < rand_samples / 4) begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       noise_func = FUNC_START;
                        1:       noise_func = FUNC_PN;
                        default: noise_func = FUNC_UNUSED;
                    endcase
                    offer(noise_func, 1'($urandom), any_sample(), any_sample(),
                          RES_PRED, '0);
                end else begin
                    offer(FUNC_SAMPLE, 1'($urandom), any_sample(), any_sample(),
                          RES_PRED, '0);
                end
                sent++;
            end
            if (phase < 3) begin
                drain();
                write_len(10'($urandom));
            end
        end

        drain();
        repeat (10) @(negedge aclk);

        $display("covered %0d input and %0d output transactions at sequence length %0d",
                 n_in, n_out, taps_len);
        $display("%0d length register writes, long output hold-off %0s",
                 n_cfg, hold_done ? "applied" : "not reached");
        if (errors == 0)
            $display("pn_sequence_correlator_power regression: pass");
        else
            $display("pn_sequence_correlator_power regression: fail");
        $finish;
    end
endmodule
